// ===== design/dtmd_pkg.sv =====
// ----------------------------------------------------------------------------
// dtmd_pkg: shared constants for the debounced toggle / EMA motor duty unit
// Widths of the sample, filter, duty and configuration paths, register
// indexes and register reset values.
// ----------------------------------------------------------------------------
package dtmd_pkg;

  // Sample and duty resolution
  localparam int unsigned ADC_BITS  = 12;
  localparam int unsigned DUTY_BITS = 10;
  localparam int unsigned FRAC_BITS = 8;   // Q1.8 alpha, Q(ADC).8 filter

  // Derived widths
  localparam int unsigned FILT_W   = ADC_BITS + FRAC_BITS;
  localparam int unsigned ALPHA_W  = FRAC_BITS + 1;
  localparam int unsigned DEB_W    = 4;
  localparam int unsigned MUL_A_W  = (DUTY_BITS > ALPHA_W) ? DUTY_BITS : ALPHA_W;
  localparam int unsigned PROD_W   = MUL_A_W + FILT_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned Y_W      = PROD_W - FRAC_BITS;
  localparam int unsigned Q_W      = Y_W + 1 - ADC_BITS;
  localparam int unsigned T_W      = Q_W + DUTY_BITS;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_W0     = (ADC_BITS > DUTY_BITS) ? ADC_BITS : DUTY_BITS;
  localparam int unsigned CFG_W1     = (CFG_W0 > ALPHA_W) ? CFG_W0 : ALPHA_W;
  localparam int unsigned CFG_W      = (CFG_W1 > DEB_W) ? CFG_W1 : DEB_W;

  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_LIMIT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_EMA_ALPHA      = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE      = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_START_DUTY = CFG_ADDR_W'(3);

  // Register reset values
  localparam logic [DEB_W-1:0]     DEBOUNCE_LIMIT_RST = DEB_W'(3);
  localparam logic [ALPHA_W-1:0]   EMA_ALPHA_RST      = ALPHA_W'(77);
  localparam logic [ADC_BITS-1:0]  DEAD_ZONE_RST      = ADC_BITS'(50);
  localparam logic [DUTY_BITS-1:0] MIN_START_RST      = DUTY_BITS'(400);

  // Full-scale values
  localparam logic [DUTY_BITS-1:0] DUTY_MAX  = '1;
  localparam logic [ADC_BITS-1:0]  ADC_MAX   = '1;
  localparam logic [ALPHA_W-1:0]   ALPHA_ONE = ALPHA_W'(1 << FRAC_BITS);

endpackage

// ===== design/debounced_toggle_ema_motor_duty_unit.sv =====
// ----------------------------------------------------------------------------
// debounced_toggle_ema_motor_duty_unit
// Button debounce with run toggle, EMA filter on the pot sample and a linear
// map of the filtered level onto a PWM duty; one duty result per sample.
// ----------------------------------------------------------------------------
// Every transaction on the input channel yields one result (duty, running).
// A button sample is handled in the accept cycle, which moves straight to
// ST_DONE. For a pot sample the filter update and the duty scaling share
// a single 10x20 multiplier that a small sequencer steps through three
// products, then the divide by full scale (a constant 2^ADC_BITS-1) is
// done by a shift-add estimate and one correction step, ahead of ST_DONE.
// The input is stalled from accept until the result is loaded into the
// output register; the output register lets the next sample enter while a
// result is still waiting. Configuration writes take effect at once and are
// only to be issued while the unit is idle.
// ----------------------------------------------------------------------------
module debounced_toggle_ema_motor_duty_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [dtmd_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [dtmd_pkg::CFG_W-1:0]           cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic                                 button_level_i,
  input  logic [dtmd_pkg::ADC_BITS-1:0]        adc_sample_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [dtmd_pkg::DUTY_BITS-1:0]       duty_o,
  output logic                                 running_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_FILT,
    ST_MUL_SPAN,
    ST_DIV_EST,
    ST_DIV_FIX,
    ST_DONE
  } state_e;

  // Configuration registers
  logic [dtmd_pkg::DEB_W-1:0]     deb_limit_q;
  logic [dtmd_pkg::ALPHA_W-1:0]   alpha_q;
  logic [dtmd_pkg::ADC_BITS-1:0]  dead_zone_q;
  logic [dtmd_pkg::DUTY_BITS-1:0] min_start_q;

  // Block state
  state_e                          state_q;
  logic                            stable_q;
  logic [dtmd_pkg::DEB_W-1:0]      mismatch_q;
  logic                            running_q;
  logic                            have_first_q;
  logic [dtmd_pkg::FILT_W-1:0]     filt_q;
  logic [dtmd_pkg::DUTY_BITS-1:0]  target_q;

  // Datapath registers
  logic [dtmd_pkg::FILT_W-1:0]     sample_q;
  logic [dtmd_pkg::PROD_W-1:0]     prod_q;
  logic [dtmd_pkg::PROD_W-1:0]     acc_q;
  logic [dtmd_pkg::Y_W-1:0]        y_q;
  logic [dtmd_pkg::Q_W-1:0]        est_q;
  logic                            above_q;

  // Output register
  logic                            out_valid_q;
  logic [dtmd_pkg::DUTY_BITS-1:0]  duty_q;
  logic                            out_run_q;

  logic in_accept;
  logic out_take;
  logic out_free;
  logic out_load;

  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_DONE) && out_free;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign running_o   = out_run_q;

  // Debounce next state, evaluated on the incoming button level
  logic [dtmd_pkg::DEB_W-1:0] mismatch_inc;
  logic                       deb_differ;
  logic                       deb_adopt;

  assign mismatch_inc = mismatch_q + dtmd_pkg::DEB_W'(1);
  assign deb_differ   = (button_level_i != stable_q);
  assign deb_adopt    = deb_differ && (mismatch_inc >= deb_limit_q);

  // Saturated alpha and its complement
  logic [dtmd_pkg::ALPHA_W-1:0] alpha_sat;
  logic [dtmd_pkg::ALPHA_W-1:0] alpha_inv;

  assign alpha_sat = (alpha_q > dtmd_pkg::ALPHA_ONE) ? dtmd_pkg::ALPHA_ONE : alpha_q;
  assign alpha_inv = dtmd_pkg::ALPHA_ONE - alpha_sat;

  // Duty span above the start duty
  logic [dtmd_pkg::DUTY_BITS-1:0] span;

  assign span = (min_start_q >= dtmd_pkg::DUTY_MAX) ? '0 : (dtmd_pkg::DUTY_MAX - min_start_q);

  // Shared multiplier and its operand select
  logic [dtmd_pkg::MUL_A_W-1:0] mul_a;
  logic [dtmd_pkg::FILT_W-1:0]  mul_b;
  logic [dtmd_pkg::PROD_W-1:0]  mul_p;

  always_comb begin
    case (state_q)
      ST_MUL_NEW: begin
        mul_a = dtmd_pkg::MUL_A_W'(alpha_sat);
        mul_b = sample_q;
      end
      ST_MUL_OLD: begin
        mul_a = dtmd_pkg::MUL_A_W'(alpha_inv);
        mul_b = filt_q;
      end
      default: begin
        mul_a = dtmd_pkg::MUL_A_W'(span);
        mul_b = filt_q;
      end
    endcase
  end

  assign mul_p = dtmd_pkg::PROD_W'(mul_a) * dtmd_pkg::PROD_W'(mul_b);

  // Filter update with round half up
  logic [dtmd_pkg::SUM_W-1:0]  filt_sum;
  logic [dtmd_pkg::FILT_W-1:0] filt_new;

  assign filt_sum = dtmd_pkg::SUM_W'(acc_q) + dtmd_pkg::SUM_W'(prod_q)
                  + dtmd_pkg::SUM_W'(dtmd_pkg::ALPHA_ONE >> 1);
  assign filt_new = filt_sum[dtmd_pkg::FILT_W+dtmd_pkg::FRAC_BITS-1:dtmd_pkg::FRAC_BITS];

  // Divide by full scale: estimate y / (2^N - 1) as (y + y>>N) >> N
  logic [dtmd_pkg::Y_W-1:0] y_val;
  logic [dtmd_pkg::Y_W:0]   est_sum;

  assign y_val   = prod_q[dtmd_pkg::PROD_W-1:dtmd_pkg::FRAC_BITS];
  assign est_sum = {1'b0, y_val} + {1'b0, y_val >> dtmd_pkg::ADC_BITS};

  // Correction: one compare and subtract on the remainder
  logic [dtmd_pkg::Y_W:0]   est_ext;
  logic [dtmd_pkg::Y_W:0]   est_scaled;
  logic [dtmd_pkg::Y_W:0]   rem;
  logic [dtmd_pkg::Q_W:0]   quot;
  logic [dtmd_pkg::T_W-1:0] tgt_sum;
  logic [dtmd_pkg::DUTY_BITS-1:0] tgt_new;

  assign est_ext    = (dtmd_pkg::Y_W+1)'(est_q);
  assign est_scaled = (est_ext << dtmd_pkg::ADC_BITS) - est_ext;
  assign rem        = {1'b0, y_q} - est_scaled;
  assign quot       = (dtmd_pkg::Q_W+1)'(est_q)
                    + (dtmd_pkg::Q_W+1)'(rem >= (dtmd_pkg::Y_W+1)'(dtmd_pkg::ADC_MAX));
  assign tgt_sum    = dtmd_pkg::T_W'(min_start_q) + dtmd_pkg::T_W'(quot);

  always_comb begin
    if (!above_q) begin
      tgt_new = '0;
    end else if (tgt_sum > dtmd_pkg::T_W'(dtmd_pkg::DUTY_MAX)) begin
      tgt_new = dtmd_pkg::DUTY_MAX;
    end else begin
      tgt_new = tgt_sum[dtmd_pkg::DUTY_BITS-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_limit_q <= dtmd_pkg::DEBOUNCE_LIMIT_RST;
      alpha_q     <= dtmd_pkg::EMA_ALPHA_RST;
      dead_zone_q <= dtmd_pkg::DEAD_ZONE_RST;
      min_start_q <= dtmd_pkg::MIN_START_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        dtmd_pkg::REG_DEBOUNCE_LIMIT: deb_limit_q <= cfg_wdata_i[dtmd_pkg::DEB_W-1:0];
        dtmd_pkg::REG_EMA_ALPHA:      alpha_q     <= cfg_wdata_i[dtmd_pkg::ALPHA_W-1:0];
        dtmd_pkg::REG_DEAD_ZONE:      dead_zone_q <= cfg_wdata_i[dtmd_pkg::ADC_BITS-1:0];
        dtmd_pkg::REG_MIN_START_DUTY: min_start_q <= cfg_wdata_i[dtmd_pkg::DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      stable_q     <= 1'b0;
      mismatch_q   <= '0;
      running_q    <= 1'b0;
      have_first_q <= 1'b0;
      filt_q       <= '0;
      target_q     <= '0;
      out_valid_q  <= 1'b0;
      duty_q       <= '0;
      out_run_q    <= 1'b0;
      sample_q     <= '0;
      prod_q       <= '0;
      acc_q        <= '0;
      y_q          <= '0;
      est_q        <= '0;
      above_q      <= 1'b0;
    end else begin
      // a new result wins over the taken one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (!req_type_i) begin
              // debounce the button sample right away
              if (!deb_differ) begin
                mismatch_q <= '0;
              end else if (deb_adopt) begin
                stable_q   <= button_level_i;
                mismatch_q <= '0;
                if (button_level_i) begin
                  running_q <= !running_q;
                end
              end else begin
                mismatch_q <= mismatch_inc;
              end
              state_q <= ST_DONE;
            end else begin
              sample_q <= {adc_sample_i, dtmd_pkg::FRAC_BITS'(0)};
              state_q  <= ST_MUL_NEW;
            end
          end
        end
        ST_MUL_NEW: begin
          prod_q  <= mul_p;
          state_q <= ST_MUL_OLD;
        end
        ST_MUL_OLD: begin
          acc_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= ST_FILT;
        end
        ST_FILT: begin
          // first sample after reset loads the filter directly
          filt_q       <= have_first_q ? filt_new : sample_q;
          have_first_q <= 1'b1;
          state_q      <= ST_MUL_SPAN;
        end
        ST_MUL_SPAN: begin
          prod_q  <= mul_p;
          above_q <= (filt_q > {dead_zone_q, dtmd_pkg::FRAC_BITS'(0)});
          state_q <= ST_DIV_EST;
        end
        ST_DIV_EST: begin
          y_q     <= y_val;
          est_q   <= est_sum[dtmd_pkg::Y_W:dtmd_pkg::ADC_BITS];
          state_q <= ST_DIV_FIX;
        end
        ST_DIV_FIX: begin
          target_q <= tgt_new;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          // load the result once the output register is free
          if (out_free) begin
            duty_q    <= running_q ? target_q : '0;
            out_run_q <= running_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
